// ----- rtl/core/bpe_pkg.sv -----
// Shared types and constants for the bouncing particle Euler step core.
`timescale 1ns / 1ps
`default_nettype none
package bpe_pkg;

   // Width of the dt and mu coefficients, one bit retired per cycle
   localparam int K_BITS = 16;
   // Fraction bits of the dt and mu coefficients
   localparam int CFG_FRAC = 16;

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_BOX_WIDTH     = 3'd0,
      REG_BOX_HEIGHT    = 3'd1,
      REG_TIME_STEP     = 3'd2,
      REG_DRAG_COEFF    = 3'd3,
      REG_GRAVITY_ACCEL = 3'd4
   } reg_idx_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Product steps of one tick, in issue order
   typedef enum logic [2:0] {
      OP_WALL_X = 3'd0,
      OP_WALL_Y = 3'd1,
      OP_DRAG_X = 3'd2,
      OP_DRAG_Y = 3'd3,
      OP_VEL_X  = 3'd4,
      OP_VEL_Y  = 3'd5,
      OP_POS_X  = 3'd6,
      OP_POS_Y  = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ISSUE = 4'b0010,
      S_MUL   = 4'b0100,
      S_FIN   = 4'b1000
   } state_type;

   // Multiplier handshake
   typedef struct packed {
      logic start;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/bouncing_particle_euler_step_core.sv -----
// Top level of the bouncing particle Euler step core: sequencer, state and registers.
//
//  channel | dir | handshake           | content
//  --------+-----+---------------------+-----------------------------------------
//  req     | in  | req_tvalid/tready   | tuser cmd, tdata load pos/vel words
//  rsp     | out | rsp_tvalid/tready   | tdata pixels, bounce and saturate flags
//  csr     | in  | csr_valid/ready     | csr_index, csr_data register write
//
// A load word goes from the finish state into the rsp register. A tick word
// runs eight products in turn on one bit-serial multiplier, each issued,
// multiplied and then applied. The multiplier is the limiting unit. Reset is
// synchronous and restores register defaults and zero particle state. A
// stalled result sits in the rsp register while the next request is taken; the
// sequencer waits only when a second result is ready before the first is taken.
`timescale 1ns / 1ps
`default_nettype none
module bouncing_particle_euler_step_core #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [127:0] req_tdata,   // load_pos_x, load_pos_y, load_vel_x, load_vel_y
   input  wire [0:0]   req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // pixel_x, pixel_y, bounced_x, bounced_y, saturated, pad
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [bpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire [bpe_pkg::CSR_DATA_BITS-1:0] csr_data
);

   // wide enough for the wall bound, gravity rescale and any sum before clipping
   localparam int TW = WORD_BITS + FRAC_BITS + 14;
   localparam int GSH_L = (FRAC_BITS >= bpe_pkg::CFG_FRAC) ? FRAC_BITS - bpe_pkg::CFG_FRAC : 0;
   localparam int GSH_R = (FRAC_BITS < bpe_pkg::CFG_FRAC) ? bpe_pkg::CFG_FRAC - FRAC_BITS : 0;
   localparam logic signed [TW-1:0] WMAX = TW'({1'b0, {(WORD_BITS-1){1'b1}}});
   localparam logic signed [TW-1:0] WMIN = -WMAX - TW'(1);
   localparam logic signed [TW-1:0] ONE = TW'(1) <<< FRAC_BITS;
   localparam logic signed [TW-1:0] PMAX = TW'(32767);
   localparam logic signed [TW-1:0] PMIN = -TW'(32768);

   typedef struct packed {
      logic signed [WORD_BITS-1:0] val;
      logic                        sat;
   } clip_type;

   function automatic clip_type wclip(input logic signed [TW-1:0] v);
      clip_type r;
      r.sat = 1'b0;
      r.val = v[WORD_BITS-1:0];
      if (v > WMAX) begin
         r.val = WMAX[WORD_BITS-1:0];
         r.sat = 1'b1;
      end else if (v < WMIN) begin
         r.val = WMIN[WORD_BITS-1:0];
         r.sat = 1'b1;
      end
      return r;
   endfunction

   function automatic logic wall_hit(input logic signed [WORD_BITS-1:0] pos,
                                     input logic signed [WORD_BITS-1:0] step,
                                     input logic [11:0] size);
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] hi;
      t  = TW'(pos) + TW'(step);
      hi = TW'($signed({1'b0, size}) - 13'sd1) <<< FRAC_BITS;
      return (t <= ONE) || (t >= hi);
   endfunction

   typedef struct packed {
      logic [15:0] pix;
      logic        sat;
   } pix_type;

   function automatic pix_type pixel_of(input logic signed [WORD_BITS-1:0] pos,
                                        input logic signed [WORD_BITS-1:0] vel);
      pix_type r;
      logic signed [TW-1:0] p;
      if (vel < 0) p = TW'(pos) >>> FRAC_BITS;
      else         p = (TW'(pos) + ONE - TW'(1)) >>> FRAC_BITS;
      r.sat = 1'b0;
      r.pix = p[15:0];
      if (p > PMAX) begin
         r.pix = PMAX[15:0];
         r.sat = 1'b1;
      end else if (p < PMIN) begin
         r.pix = PMIN[15:0];
         r.sat = 1'b1;
      end
      return r;
   endfunction

   // config registers
   logic [11:0]        box_w_ff, box_h_ff;
   logic [15:0]        dt_ff, mu_ff;
   logic signed [23:0] g_ff;

   // particle state and scratch
   logic signed [WORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [WORD_BITS-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [WORD_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic                        bx_ff, bx_in, by_ff, by_in, sat_ff, sat_in;
   bpe_pkg::state_type          state_ff, state_in;
   bpe_pkg::op_type             op_ff, op_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   // multiplier
   bpe_pkg::mul_ctl_type          mctl;
   bpe_pkg::mul_sts_type          msts;
   logic signed [WORD_BITS-1:0]   m_a;
   logic [bpe_pkg::K_BITS-1:0]    m_k;
   logic signed [WORD_BITS-1:0]   m_p;

   bpe_ser_mul #(.WORD_BITS(WORD_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mctl),
      .a_val (m_a),
      .k_val (m_k),
      .sts   (msts),
      .prod  (m_p)
   );

   logic req_acc, rsp_free;
   logic signed [TW-1:0] gfix;
   clip_type c0, c1, c2, c3;
   pix_type  pxo, pyo;

   assign req_tready = (state_ff == bpe_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign gfix       = (TW'(g_ff) <<< GSH_L) >>> GSH_R;
   assign mctl.start = (state_ff == bpe_pkg::S_ISSUE);

   // operand select per step
   always_comb begin
      case (op_ff)
         bpe_pkg::OP_WALL_X: begin m_a = vx_ff; m_k = dt_ff; end
         bpe_pkg::OP_WALL_Y: begin m_a = vy_ff; m_k = dt_ff; end
         bpe_pkg::OP_DRAG_X: begin m_a = vx_ff; m_k = mu_ff; end
         bpe_pkg::OP_DRAG_Y: begin m_a = vy_ff; m_k = mu_ff; end
         bpe_pkg::OP_VEL_X:  begin m_a = ax_ff; m_k = dt_ff; end
         bpe_pkg::OP_VEL_Y:  begin m_a = ay_ff; m_k = dt_ff; end
         bpe_pkg::OP_POS_X:  begin m_a = vx_ff; m_k = dt_ff; end
         bpe_pkg::OP_POS_Y:  begin m_a = vy_ff; m_k = dt_ff; end
         default:            begin m_a = vx_ff; m_k = dt_ff; end
      endcase
   end

   always_comb begin
      pxo = pixel_of(px_ff, vx_ff);
      pyo = pixel_of(py_ff, vy_ff);
   end

   always_comb begin
      px_in = px_ff; py_in = py_ff; vx_in = vx_ff; vy_in = vy_ff;
      ax_in = ax_ff; ay_in = ay_ff;
      bx_in = bx_ff; by_in = by_ff; sat_in = sat_ff;
      state_in = state_ff; op_in = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      c0 = wclip(TW'($signed(req_tdata[31:0])));
      c1 = wclip(TW'($signed(req_tdata[63:32])));
      c2 = wclip(TW'($signed(req_tdata[95:64])));
      c3 = wclip(TW'($signed(req_tdata[127:96])));
      case (state_ff)
         bpe_pkg::S_IDLE: begin
            if (req_acc) begin
               bx_in = 1'b0;
               by_in = 1'b0;
               op_in = bpe_pkg::OP_WALL_X;
               if (req_tuser[0] == bpe_pkg::CMD_LOAD) begin
                  px_in = c0.val; py_in = c1.val; vx_in = c2.val; vy_in = c3.val;
                  sat_in = c0.sat | c1.sat | c2.sat | c3.sat;
                  state_in = bpe_pkg::S_FIN;
               end else begin
                  sat_in = 1'b0;
                  state_in = bpe_pkg::S_ISSUE;
               end
            end
         end
         bpe_pkg::S_ISSUE: state_in = bpe_pkg::S_MUL;
         bpe_pkg::S_MUL: begin
            if (msts.done) begin
               state_in = bpe_pkg::S_ISSUE;
               op_in = bpe_pkg::op_type'(op_ff + 3'd1);
               case (op_ff)
                  bpe_pkg::OP_WALL_X: bx_in = wall_hit(px_ff, m_p, box_w_ff);
                  bpe_pkg::OP_WALL_Y: begin
                     // reflect both axes once both tests are known
                     by_in = wall_hit(py_ff, m_p, box_h_ff);
                     c0 = wclip(-TW'(vx_ff));
                     c1 = wclip(-TW'(vy_ff));
                     if (bx_ff) begin vx_in = c0.val; sat_in = sat_ff | c0.sat; end
                     if (by_in) begin vy_in = c1.val; sat_in = sat_in | c1.sat; end
                  end
                  bpe_pkg::OP_DRAG_X: begin
                     c0 = wclip(-TW'(m_p));
                     ax_in = c0.val; sat_in = sat_ff | c0.sat;
                  end
                  bpe_pkg::OP_DRAG_Y: begin
                     c0 = wclip(gfix - TW'(m_p));
                     ay_in = c0.val; sat_in = sat_ff | c0.sat;
                  end
                  bpe_pkg::OP_VEL_X: begin
                     c0 = wclip(TW'(vx_ff) + TW'(m_p));
                     vx_in = c0.val; sat_in = sat_ff | c0.sat;
                  end
                  bpe_pkg::OP_VEL_Y: begin
                     c0 = wclip(TW'(vy_ff) + TW'(m_p));
                     vy_in = c0.val; sat_in = sat_ff | c0.sat;
                  end
                  bpe_pkg::OP_POS_X: begin
                     c0 = wclip(TW'(px_ff) + TW'(m_p));
                     px_in = c0.val; sat_in = sat_ff | c0.sat;
                  end
                  bpe_pkg::OP_POS_Y: begin
                     c0 = wclip(TW'(py_ff) + TW'(m_p));
                     py_in = c0.val; sat_in = sat_ff | c0.sat;
                     state_in = bpe_pkg::S_FIN;
                  end
                  default: ;
               endcase
            end
         end
         bpe_pkg::S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {5'b0, sat_ff | pxo.sat | pyo.sat, by_ff, bx_ff,
                              pyo.pix, pxo.pix};
               state_in = bpe_pkg::S_IDLE;
            end
         end
         default: state_in = bpe_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpe_pkg::S_IDLE;
         op_ff        <= bpe_pkg::OP_WALL_X;
         rsp_valid_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; vx_ff <= '0; vy_ff <= '0;
         bx_ff <= 1'b0; by_ff <= 1'b0; sat_ff <= 1'b0;
         box_w_ff <= 12'd120;
         box_h_ff <= 12'd120;
         dt_ff    <= 16'd1092;
         mu_ff    <= 16'd6554;
         g_ff     <= 24'sd642253;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         px_ff <= px_in; py_ff <= py_in; vx_ff <= vx_in; vy_ff <= vy_in;
         bx_ff <= bx_in; by_ff <= by_in; sat_ff <= sat_in;
         if (csr_valid) begin
            case (csr_index)
               bpe_pkg::REG_BOX_WIDTH:     box_w_ff <= csr_data[11:0];
               bpe_pkg::REG_BOX_HEIGHT:    box_h_ff <= csr_data[11:0];
               bpe_pkg::REG_TIME_STEP:     dt_ff    <= csr_data[15:0];
               bpe_pkg::REG_DRAG_COEFF:    mu_ff    <= csr_data[15:0];
               bpe_pkg::REG_GRAVITY_ACCEL: g_ff     <= $signed(csr_data);
               default: ;
            endcase
         end
      end
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // multiplier finishes only while the sequencer waits on it
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      msts.done |-> (state_ff == bpe_pkg::S_MUL))
      else $error("multiplier done outside S_MUL");

   // multiplier runs only while the sequencer waits on it
   a_mul_busy: assert property (@(posedge clock) disable iff (reset)
      msts.busy |-> (state_ff == bpe_pkg::S_MUL))
      else $error("multiplier busy outside S_MUL");

   // a tick starts at the first product step
   a_tick_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[0] == bpe_pkg::CMD_TICK) |=>
         (state_ff == bpe_pkg::S_ISSUE && op_ff == bpe_pkg::OP_WALL_X))
      else $error("tick did not start at wall step");

   // a load reports no bounce
   a_load_fin: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser[0] == bpe_pkg::CMD_LOAD) |=>
         (state_ff == bpe_pkg::S_FIN && !bx_ff && !by_ff))
      else $error("load did not go to finish cleanly");

   // finishing posts a result and frees the request side
   a_fin_post: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpe_pkg::S_FIN && rsp_free) |=>
         (rsp_valid_ff && state_ff == bpe_pkg::S_IDLE))
      else $error("result not posted on finish");

endmodule
`default_nettype wire

// ----- rtl/core/bpe_ser_mul.sv -----
// Bit-serial signed by unsigned multiplier with floor shift by the coefficient fraction.
`timescale 1ns / 1ps
`default_nettype none
module bpe_ser_mul #(
   parameter int WORD_BITS = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire bpe_pkg::mul_ctl_type    ctl,
   input  wire logic signed [WORD_BITS-1:0] a_val,
   input  wire logic [bpe_pkg::K_BITS-1:0]  k_val,
   output bpe_pkg::mul_sts_type         sts,
   output logic signed [WORD_BITS-1:0]  prod
);

   localparam int AW = WORD_BITS + bpe_pkg::K_BITS;
   localparam int CW = $clog2(bpe_pkg::K_BITS + 1);

   logic signed [AW-1:0]          acc_ff, acc_in;
   logic signed [WORD_BITS-1:0]   a_ff, a_in;
   logic [bpe_pkg::K_BITS-1:0]    k_ff, k_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   // MSB first: double and add
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         acc_in  = '0;
         a_in    = a_val;
         k_in    = k_val;
         cnt_in  = CW'(bpe_pkg::K_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (acc_ff <<< 1) + (k_ff[bpe_pkg::K_BITS-1] ? AW'(a_ff) : AW'(0));
         k_in   = k_ff << 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      k_ff   <= k_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   // arithmetic shift is the floor
   assign prod = acc_ff[AW-1:bpe_pkg::CFG_FRAC];

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the bouncing particle Euler step core.
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic               bx;
      logic               by;
      logic               sat;
   } pixel_word_type;

   typedef struct {
      bit          cmd;
      logic [31:0] lpx, lpy, lvx, lvy;
      bit          typed;     // expected word typed in below
      pixel_word_type want;
   } stim_row_type;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;
   localparam longint ONE  = 64'sd65536;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [127:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid, rsp_tready;
   logic [39:0]  rsp_tdata;
   logic         csr_valid, csr_ready;
   logic [bpe_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [bpe_pkg::CSR_DATA_BITS-1:0] csr_data;

   bouncing_particle_euler_step_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // particle model: registers and state, all held wide
   longint box_w, box_h, dt, mu, grav;
   longint pos_x, pos_y, vel_x, vel_y;
   bit     clipped;

   pixel_word_type pending_pixels[$];
   int errors;
   int tx_idle_pct, rx_idle_pct;
   int quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // clip to the signed 32-bit word range, noting any clip
   function automatic longint word_clip(longint v);
      if (v > WMAX) begin
         clipped = 1'b1;
         return WMAX;
      end
      if (v < WMIN) begin
         clipped = 1'b1;
         return WMIN;
      end
      return v;
   endfunction

   // product with a Q0.16 coefficient, floor rounding
   function automatic longint mul_q16(longint v, longint k);
      return (v * k) >>> 16;
   endfunction

   function automatic bit hits_wall(longint p, longint v, longint size);
      longint t;
      t = p + mul_q16(v, dt);
      return (t <= ONE) || (t >= (size - 1) * ONE);
   endfunction

   // floor when moving negative, ceil otherwise; clipped to 16 bits
   function automatic logic [15:0] pixel_of(longint p, longint v);
      longint q;
      q = (v < 0) ? (p >>> 16) : ((p + ONE - 1) >>> 16);
      if (q > 32767) begin
         clipped = 1'b1;
         q = 32767;
      end else if (q < -32768) begin
         clipped = 1'b1;
         q = -32768;
      end
      return q[15:0];
   endfunction

   function automatic pixel_word_type step_particle(bit cmd, logic [31:0] lpx,
                                                    logic [31:0] lpy,
                                                    logic [31:0] lvx, logic [31:0] lvy);
      pixel_word_type r;
      longint ax, ay;
      clipped = 1'b0;
      r.bx = 1'b0;
      r.by = 1'b0;
      if (cmd == bpe_pkg::CMD_LOAD) begin
         pos_x = longint'($signed(lpx));
         pos_y = longint'($signed(lpy));
         vel_x = longint'($signed(lvx));
         vel_y = longint'($signed(lvy));
      end else begin
         if (hits_wall(pos_x, vel_x, box_w)) begin
            vel_x = word_clip(-vel_x);
            r.bx = 1'b1;
         end
         if (hits_wall(pos_y, vel_y, box_h)) begin
            vel_y = word_clip(-vel_y);
            r.by = 1'b1;
         end
         ax = word_clip(-mul_q16(vel_x, mu));
         ay = word_clip(grav - mul_q16(vel_y, mu));
         vel_x = word_clip(vel_x + mul_q16(ax, dt));
         vel_y = word_clip(vel_y + mul_q16(ay, dt));
         pos_x = word_clip(pos_x + mul_q16(vel_x, dt));
         pos_y = word_clip(pos_y + mul_q16(vel_y, dt));
      end
      r.px = pixel_of(pos_x, vel_x);
      r.py = pixel_of(pos_y, vel_y);
      r.sat = clipped;
      return r;
   endfunction

   // receiver: random stall, compare each word with the oldest expectation
   always @(posedge clock) begin
      pixel_word_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.px  = rsp_tdata[15:0];
            got.py  = rsp_tdata[31:16];
            got.bx  = rsp_tdata[32];
            got.by  = rsp_tdata[33];
            got.sat = rsp_tdata[34];
            if (pending_pixels.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               errors++;
            end else begin
               want = pending_pixels.pop_front();
               if (got.px !== want.px) begin
                  $error("pixel_x exp %0d got %0d", want.px, got.px);
                  errors++;
               end
               if (got.py !== want.py) begin
                  $error("pixel_y exp %0d got %0d", want.py, got.py);
                  errors++;
               end
               if (got.bx !== want.bx) begin
                  $error("bounced_x exp %0d got %0d", want.bx, got.bx);
                  errors++;
               end
               if (got.by !== want.by) begin
                  $error("bounced_y exp %0d got %0d", want.by, got.by);
                  errors++;
               end
               if (got.sat !== want.sat) begin
                  $error("saturated exp %0d got %0d", want.sat, got.sat);
                  errors++;
               end
            end
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic send_word(bit cmd, logic [31:0] lpx, logic [31:0] lpy,
                            logic [31:0] lvx, logic [31:0] lvy,
                            bit typed, pixel_word_type want);
      pixel_word_type r;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {lvy, lvx, lpy, lpx};
      do @(posedge clock); while (!req_tready);
      r = step_particle(cmd, lpx, lpy, lvx, lvy);
      pending_pixels.push_back(typed ? want : r);
   endtask

   // block must be idle: all results in, then the tick latency again
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // raises csr_valid and leaves it high; the caller drops it after the last write
   task automatic write_reg(bpe_pkg::reg_idx_type idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bpe_pkg::REG_BOX_WIDTH:  box_w = value[11:0];
         bpe_pkg::REG_BOX_HEIGHT: box_h = value[11:0];
         bpe_pkg::REG_TIME_STEP:  dt = value[15:0];
         bpe_pkg::REG_DRAG_COEFF: mu = value[15:0];
         default:                 grav = longint'($signed(value));
      endcase
   endtask

   task automatic write_all(logic [11:0] w, logic [11:0] h, logic [15:0] t,
                            logic [15:0] m, logic [23:0] g);
      wait_idle();
      write_reg(bpe_pkg::REG_BOX_WIDTH, {12'd0, w});
      write_reg(bpe_pkg::REG_BOX_HEIGHT, {12'd0, h});
      write_reg(bpe_pkg::REG_TIME_STEP, {8'd0, t});
      write_reg(bpe_pkg::REG_DRAG_COEFF, {8'd0, m});
      write_reg(bpe_pkg::REG_GRAVITY_ACCEL, g);
      csr_valid <= 1'b0;
   endtask

   // mostly ticks; loads usually place the particle inside the box
   task automatic random_run(int count, bit hold_mid);
      logic [31:0] a, b, c, d;
      int k;
      pixel_word_type none;
      none = '0;
      for (k = 0; k < count; k++) begin
         if (hold_mid && k == count / 2) begin
            req_tvalid <= 1'b0;
            while (pending_pixels.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 80) begin
            send_word(bpe_pkg::CMD_TICK, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
         end else begin
            if ($urandom_range(3) != 0) begin
               a = $urandom_range(32'(box_w * 65536));
               b = $urandom_range(32'(box_h * 65536));
               c = $urandom_range(40 << 16) - (20 << 16);
               d = $urandom_range(40 << 16) - (20 << 16);
            end else begin
               a = $urandom;
               b = $urandom;
               c = $urandom;
               d = $urandom;
            end
            send_word(bpe_pkg::CMD_LOAD, a, b, c, d, 1'b0, none);
         end
      end
   endtask

   stim_row_type dir_rows[17];

   initial begin
      int i;
      errors = 0;
      tx_idle_pct = 11;
      rx_idle_pct = 70;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      box_w = 120; box_h = 120; dt = 1092; mu = 6554; grav = 642253;
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;

      // directed rows: tick from reset, position and velocity extremes,
      // negation of the most negative velocity, floor versus ceil pixels
      dir_rows[0]  = '{1, 0, 0, 0, 0, 0, '0};
      dir_rows[1]  = '{0, 0, 0, 0, 0, 1, '{16'sd0, 16'sd0, 0, 0, 0}};
      dir_rows[2]  = '{0, 32'h7fffffff, 32'h7fffffff, 0, 0, 1,
                       '{16'sd32767, 16'sd32767, 0, 0, 1}};
      dir_rows[3]  = '{0, 32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff, 1,
                       '{-16'sd32768, -16'sd32768, 0, 0, 0}};
      dir_rows[4]  = '{1, 0, 0, 0, 0, 0, '0};
      dir_rows[5]  = '{0, 60 << 16, 60 << 16, 32'h80000000, 32'h80000000, 1,
                       '{16'sd60, 16'sd60, 0, 0, 0}};
      dir_rows[6]  = '{1, 0, 0, 0, 0, 0, '0};
      dir_rows[7]  = '{0, 60 << 16, 60 << 16, 32'h7fffffff, 32'h7fffffff, 1,
                       '{16'sd60, 16'sd60, 0, 0, 0}};
      dir_rows[8]  = '{1, 0, 0, 0, 0, 0, '0};
      dir_rows[9]  = '{0, (50 << 16) | 32'h8000, (50 << 16) | 32'h8000, 3 << 16,
                       -(2 << 16), 1, '{16'sd51, 16'sd50, 0, 0, 0}};
      for (i = 10; i < 15; i++) dir_rows[i] = '{1, 0, 0, 0, 0, 0, '0};
      dir_rows[15] = '{0, 32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa, 0, '0};
      dir_rows[16] = '{1, 0, 0, 0, 0, 0, '0};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_word(dir_rows[i].cmd, dir_rows[i].lpx, dir_rows[i].lpy, dir_rows[i].lvx,
                   dir_rows[i].lvy, dir_rows[i].typed, dir_rows[i].want);

      // mid-range random registers, slow receiver
      write_all(12'($urandom_range(4095, 40)), 12'($urandom_range(4095, 40)),
                16'($urandom_range(4000, 200)), 16'($urandom),
                24'($urandom_range(2000000) - 1000000));
      random_run(150, 1'b1);

      // low extremes: degenerate box, no time step, no drag, strongest upward pull
      tx_idle_pct = 70;
      rx_idle_pct = 11;
      write_all(12'd2, 12'd2, 16'd0, 16'd0, 24'h800000);
      random_run(150, 1'b0);

      // high extremes
      write_all(12'd4095, 12'd4095, 16'hffff, 16'hffff, 24'h7fffff);
      random_run(150, 1'b0);

      // back near the default box, no idling
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_all(12'd120, 12'd100, 16'd1092, 16'd6554, 24'd642253);
      random_run(150, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
